### sv/spectrum_smooth_peak_hold_assert.svh
// Assertion macros shared by the spectrum smoothing and peak hold RTL.
`ifndef SPECTRUM_SMOOTH_PEAK_HOLD_ASSERT_SVH
`define SPECTRUM_SMOOTH_PEAK_HOLD_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SSPH_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ssph assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SSPH_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssph assertion failed");

`endif

### sv/ssph_pkg.sv
// Types, constants and tables shared by the spectrum smoothing and peak hold block.
package ssph_pkg;

  // Frame and window geometry.
  localparam int FRAME_BINS  = 512;
  localparam int HALF_WINDOW = 5;
  localparam int WIN_LEN     = 2 * HALF_WINDOW + 1;
  localparam int MAG_BITS    = 16;
  localparam int BIN_W       = 9;
  localparam int SUM_W       = 20;
  localparam int CNT_W       = 4;
  localparam int WIDX_W      = 4;
  localparam int STEP_W      = 3;

  // Divider by reciprocal: floor(sum / cnt) = (sum * recip(cnt)) >> RECIP_SHIFT.
  localparam int RECIP_W     = 22;
  localparam int RECIP_SHIFT = 24;
  localparam int PROD_W      = SUM_W + RECIP_W;

  // Output queue depth, also the credit limit for results in flight.
  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_AW     = 3;
  localparam int FIFO_CW     = 4;

  // Configuration register file.
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;
  localparam logic REG_DECAY_IDX = 1'b0;
  localparam logic [15:0] DECAY_RESET = 16'd64225;

  typedef logic [MAG_BITS-1:0] mag_t;
  typedef logic [BIN_W-1:0]    bin_t;
  typedef logic [SUM_W-1:0]    sum_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [WIDX_W-1:0]   widx_t;
  typedef logic [STEP_W-1:0]   step_t;
  typedef logic [RECIP_W-1:0]  recip_t;
  typedef logic [PROD_W-1:0]   prod_t;

  localparam bin_t LAST_BIN = bin_t'(FRAME_BINS - 1);

  typedef enum logic {
    ST_RUN,
    ST_FLUSH
  } seq_state_t;

  typedef struct packed {
    bin_t bin_index;
    mag_t current_value;
    mag_t smoothed_value;
    mag_t peak_value;
    logic last_of_run;
  } result_t;

  // Rounded-up reciprocals of the window sizes, scaled by 2**RECIP_SHIFT.
  // The rounding error times the largest sum stays below 2**RECIP_SHIFT,
  // so the truncated product equals the exact quotient.
  function automatic recip_t recip(cnt_t cnt);
    recip_t r;
    case (cnt)
      4'd6:    r = recip_t'(2796203);
      4'd7:    r = recip_t'(2396746);
      4'd8:    r = recip_t'(2097152);
      4'd9:    r = recip_t'(1864136);
      4'd10:   r = recip_t'(1677722);
      4'd11:   r = recip_t'(1525202);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### sv/ssph_stream_if.sv
// Valid/ready stream interfaces for spectrum bins and smoothed results.

interface ssph_mag_if;
  logic              valid;
  logic              ready;
  ssph_pkg::mag_t    magnitude;

  modport source (output valid, output magnitude, input ready);
  modport sink   (input valid, input magnitude, output ready);
endinterface

interface ssph_res_if;
  logic              valid;
  logic              ready;
  ssph_pkg::bin_t    bin_index;
  ssph_pkg::mag_t    current_value;
  ssph_pkg::mag_t    smoothed_value;
  ssph_pkg::mag_t    peak_value;
  logic              last_of_run;

  modport source (
    output valid, output bin_index, output current_value, output smoothed_value,
    output peak_value, output last_of_run, input ready
  );
  modport sink (
    input valid, input bin_index, input current_value, input smoothed_value,
    input peak_value, input last_of_run, output ready
  );
endinterface

### sv/spectrum_smooth_peak_hold.sv
// Spectrum smoothing over an eleven-bin window with per-bin decaying peak hold.
//
// Usage: spectrum takes one bin magnitude per transaction, bins 0..511 of a frame in
// order, frame after frame. result gives one transaction per bin: its index, its own
// magnitude, the truncated mean of the bins within five either side (clipped at the
// frame edges) and the peak, which is the stored peak times decay_factor (Q0.16)
// replaced by the mean when the mean is not smaller.
// The result for bin m is issued when bin m+5 is accepted and passes the issue, stage
// 1 and stage 2 registers into the output queue. Bins 0..4 of a frame give no result
// of their own; bin 511 gives six. Throughput: one bin per cycle while credit lasts,
// except that after bin 511 the input is held while the flush sequencer issues the
// remaining results. The peak store is one 512x16 memory, read once and written once
// per result. Reset clears the sequencer and queues and loads decay_factor with 64225;
// the peak store reads as zero until the first complete frame has been written, so no
// clearing pass is needed and input is taken from the first cycle after reset. Stall:
// results wait in an eight-entry output queue; input is refused when eight results are
// queued or in flight. Configuration is written through the APB port at byte address
// 0; the user must write it only while the block is idle; the block does not enforce it.
module spectrum_smooth_peak_hold (
  input  logic                                 clk,
  input  logic                                 rst,
  ssph_mag_if.sink                             spectrum,
  ssph_res_if.source                           result,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ssph_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [ssph_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [ssph_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready
);

  `include "spectrum_smooth_peak_hold_assert.svh"

  // Configuration.
  logic [15:0]              decay_factor;
  logic                     cfg_write;

  // Input window and bin sequencing.
  ssph_pkg::mag_t           window [ssph_pkg::WIN_LEN];
  ssph_pkg::sum_t           window_sum;
  ssph_pkg::sum_t           window_sum_next;
  ssph_pkg::bin_t           bin_counter;
  ssph_pkg::seq_state_t     state;
  ssph_pkg::seq_state_t     state_next;
  ssph_pkg::step_t          flush_step;
  ssph_pkg::step_t          flush_step_next;
  ssph_pkg::widx_t          tail_idx;
  ssph_pkg::widx_t          cur_idx;
  logic                     in_ready;
  logic                     accept;

  // Credit for results issued but not yet taken.
  logic [ssph_pkg::FIFO_CW-1:0] reserved;
  logic                     can_issue;
  logic                     issue_fire;

  // Issue stage.
  logic                     i_valid;
  ssph_pkg::bin_t           i_bin;
  ssph_pkg::bin_t           i_bin_next;
  ssph_pkg::sum_t           i_sum;
  ssph_pkg::sum_t           i_sum_next;
  ssph_pkg::mag_t           i_cur;
  ssph_pkg::mag_t           i_cur_next;
  ssph_pkg::cnt_t           i_cnt;
  ssph_pkg::cnt_t           i_cnt_next;
  logic                     i_last;
  logic                     i_last_next;

  // Peak memory and the read-modify-write stages.
  ssph_pkg::mag_t           peak_mem [ssph_pkg::FRAME_BINS];
  ssph_pkg::mag_t           rd_peak;
  ssph_pkg::mag_t           peak_eff;
  logic                     primed;
  logic                     p1_valid;
  ssph_pkg::bin_t           p1_bin;
  ssph_pkg::mag_t           p1_cur;
  logic                     p1_last;
  ssph_pkg::prod_t          p1_prod;
  logic                     p2_valid;
  ssph_pkg::bin_t           p2_bin;
  ssph_pkg::mag_t           p2_cur;
  logic                     p2_last;
  ssph_pkg::mag_t           p2_mean;
  logic [31:0]              p2_decay_prod;
  ssph_pkg::mag_t           decayed;
  ssph_pkg::mag_t           new_peak;

  // Output queue.
  ssph_pkg::result_t        fifo_mem [ssph_pkg::FIFO_DEPTH];
  logic [ssph_pkg::FIFO_AW-1:0] wr_ptr;
  logic [ssph_pkg::FIFO_AW-1:0] rd_ptr;
  logic [ssph_pkg::FIFO_CW-1:0] fifo_count;
  ssph_pkg::result_t        head;
  logic                     out_fire;

  // APB register access; the register index is the word address.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == ssph_pkg::REG_DECAY_IDX) ?
                     ssph_pkg::APB_DATA_W'(decay_factor) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_factor <= ssph_pkg::DECAY_RESET;
    end else if (cfg_write && paddr[2] == ssph_pkg::REG_DECAY_IDX) begin
      decay_factor <= pwdata[15:0];
    end
  end

  // Handshakes.
  assign spectrum.ready = in_ready;
  assign accept         = spectrum.valid && in_ready;
  assign can_issue      = reserved < ssph_pkg::FIFO_CW'(ssph_pkg::FIFO_DEPTH);
  assign out_fire       = result.valid && result.ready;

  // Sum of the samples of the present frame among the last eleven.
  always_comb begin
    if (bin_counter == '0) begin
      window_sum_next = ssph_pkg::sum_t'(spectrum.magnitude);
    end else if (bin_counter >= ssph_pkg::bin_t'(ssph_pkg::WIN_LEN)) begin
      window_sum_next = window_sum + ssph_pkg::sum_t'(spectrum.magnitude)
                        - ssph_pkg::sum_t'(window[ssph_pkg::WIN_LEN-1]);
    end else begin
      window_sum_next = window_sum + ssph_pkg::sum_t'(spectrum.magnitude);
    end
  end

  // Sample window shift line and bin counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_counter <= '0;
      window_sum  <= '0;
    end else if (accept) begin
      bin_counter <= bin_counter + ssph_pkg::bin_t'(1);
      window_sum  <= window_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      window[0] <= spectrum.magnitude;
      for (int i = 1; i < ssph_pkg::WIN_LEN; i++) begin
        window[i] <= window[i-1];
      end
    end
  end

  // Window taps used while flushing the end of a frame.
  assign tail_idx = ssph_pkg::widx_t'(ssph_pkg::WIN_LEN) - ssph_pkg::widx_t'(flush_step);
  assign cur_idx  = ssph_pkg::widx_t'(ssph_pkg::HALF_WINDOW) - ssph_pkg::widx_t'(flush_step);

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ssph_pkg::ST_RUN;
      flush_step <= '0;
    end else begin
      state      <= state_next;
      flush_step <= flush_step_next;
    end
  end

  // Sequencer: one result per accepted bin from bin 5 on, then five more at the end of a frame.
  always_comb begin
    state_next      = state;
    flush_step_next = flush_step;
    in_ready        = 1'b0;
    issue_fire      = 1'b0;
    i_bin_next      = i_bin;
    i_sum_next      = i_sum;
    i_cur_next      = i_cur;
    i_cnt_next      = i_cnt;
    i_last_next     = i_last;
    case (state)
      ssph_pkg::ST_RUN: begin
        in_ready = can_issue;
        if (spectrum.valid && can_issue) begin
          if (bin_counter >= ssph_pkg::bin_t'(ssph_pkg::HALF_WINDOW)) begin
            issue_fire  = 1'b1;
            i_bin_next  = bin_counter - ssph_pkg::bin_t'(ssph_pkg::HALF_WINDOW);
            i_sum_next  = window_sum_next;
            i_cur_next  = window[ssph_pkg::HALF_WINDOW-1];
            i_last_next = 1'b0;
            if (bin_counter >= ssph_pkg::bin_t'(ssph_pkg::WIN_LEN - 1)) begin
              i_cnt_next = ssph_pkg::cnt_t'(ssph_pkg::WIN_LEN);
            end else begin
              i_cnt_next = ssph_pkg::cnt_t'(bin_counter) + ssph_pkg::cnt_t'(1);
            end
          end
          if (bin_counter == ssph_pkg::LAST_BIN) begin
            state_next      = ssph_pkg::ST_FLUSH;
            flush_step_next = ssph_pkg::step_t'(1);
          end
        end
      end
      ssph_pkg::ST_FLUSH: begin
        if (can_issue) begin
          issue_fire  = 1'b1;
          i_bin_next  = i_bin + ssph_pkg::bin_t'(1);
          i_sum_next  = i_sum - ssph_pkg::sum_t'(window[tail_idx]);
          i_cur_next  = window[cur_idx];
          i_cnt_next  = ssph_pkg::cnt_t'(ssph_pkg::WIN_LEN) - ssph_pkg::cnt_t'(flush_step);
          i_last_next = (flush_step == ssph_pkg::step_t'(ssph_pkg::HALF_WINDOW));
          if (i_last_next) begin
            state_next      = ssph_pkg::ST_RUN;
            flush_step_next = '0;
          end else begin
            flush_step_next = flush_step + ssph_pkg::step_t'(1);
          end
        end
      end
      default: begin
        state_next      = ssph_pkg::ST_RUN;
        flush_step_next = '0;
      end
    endcase
  end

  // Credit counter covers the issue stage, the pipeline and the output queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      reserved <= '0;
    end else begin
      reserved <= reserved + ssph_pkg::FIFO_CW'(issue_fire) - ssph_pkg::FIFO_CW'(out_fire);
    end
  end

  // Issue stage registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      i_valid <= 1'b0;
    end else begin
      i_valid <= issue_fire;
    end
  end

  always_ff @(posedge clk) begin
    i_bin  <= i_bin_next;
    i_sum  <= i_sum_next;
    i_cur  <= i_cur_next;
    i_cnt  <= i_cnt_next;
    i_last <= i_last_next;
  end

  // Peak memory: read at the issue stage, written back two stages later. The same
  // bin comes around only once per frame, so a read never meets a pending write.
  always_ff @(posedge clk) begin
    rd_peak <= peak_mem[i_bin];
    if (p2_valid) begin
      peak_mem[p2_bin] <= new_peak;
    end
  end

  // Until the first frame has written every bin, stored peaks read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      primed <= 1'b0;
    end else if (p2_valid && p2_last) begin
      primed <= 1'b1;
    end
  end

  assign peak_eff = primed ? rd_peak : '0;

  // Valid bits of the pipeline stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      p1_valid <= i_valid;
      p2_valid <= p1_valid;
    end
  end

  // Stage 1: mean by reciprocal multiply. Stage 2: decay multiply.
  always_ff @(posedge clk) begin
    p1_bin        <= i_bin;
    p1_cur        <= i_cur;
    p1_last       <= i_last;
    p1_prod       <= ssph_pkg::prod_t'(i_sum) * ssph_pkg::prod_t'(ssph_pkg::recip(i_cnt));
    p2_bin        <= p1_bin;
    p2_cur        <= p1_cur;
    p2_last       <= p1_last;
    p2_mean       <= p1_prod[ssph_pkg::RECIP_SHIFT +: ssph_pkg::MAG_BITS];
    p2_decay_prod <= 32'(peak_eff) * 32'(decay_factor);
  end

  // Peak update: the mean replaces the decayed peak when it is not smaller.
  assign decayed  = p2_decay_prod[31:16];
  assign new_peak = (p2_mean >= decayed) ? p2_mean : decayed;

  // Output queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (p2_valid) begin
        wr_ptr <= wr_ptr + ssph_pkg::FIFO_AW'(1);
      end
      if (out_fire) begin
        rd_ptr <= rd_ptr + ssph_pkg::FIFO_AW'(1);
      end
      fifo_count <= fifo_count + ssph_pkg::FIFO_CW'(p2_valid) - ssph_pkg::FIFO_CW'(out_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (p2_valid) begin
      fifo_mem[wr_ptr] <= '{bin_index:      p2_bin,
                            current_value:  p2_cur,
                            smoothed_value: p2_mean,
                            peak_value:     new_peak,
                            last_of_run:    p2_last};
    end
  end

  assign head                  = fifo_mem[rd_ptr];
  assign result.valid          = (fifo_count != '0);
  assign result.bin_index      = head.bin_index;
  assign result.current_value  = head.current_value;
  assign result.smoothed_value = head.smoothed_value;
  assign result.peak_value     = head.peak_value;
  assign result.last_of_run    = head.last_of_run;

  // Credit never exceeds the queue depth.
  `SSPH_ASSERT_IMPL(a_credit_bound, clk, rst, 1'b1, reserved <= ssph_pkg::FIFO_CW'(ssph_pkg::FIFO_DEPTH))
  // A result leaving the pipeline always finds room in the queue.
  `SSPH_ASSERT_IMPL(a_queue_room, clk, rst, p2_valid, fifo_count < ssph_pkg::FIFO_CW'(ssph_pkg::FIFO_DEPTH))
  // Accepting the last bin of a frame starts the flush.
  `SSPH_ASSERT_NEXT(a_flush_start, clk, rst, accept && bin_counter == ssph_pkg::LAST_BIN, state == ssph_pkg::ST_FLUSH)
  // Window size handed to the divider stays within the reciprocal table.
  `SSPH_ASSERT_IMPL(a_cnt_range, clk, rst, i_valid, i_cnt >= ssph_pkg::cnt_t'(ssph_pkg::HALF_WINDOW + 1) && i_cnt <= ssph_pkg::cnt_t'(ssph_pkg::WIN_LEN))
  // The end-of-frame mark rides only on the last bin.
  `SSPH_ASSERT_IMPL(a_last_bin, clk, rst, result.valid && result.last_of_run, result.bin_index == ssph_pkg::LAST_BIN)

endmodule
